// ===== src/lcdseq_pkg.sv =====
// Shared types, codes and transfer tables for the character LCD nibble sequencer.
`default_nettype none
package lcdseq_pkg;

  // Request modes carried in the low bits of the input word.
  localparam logic [1:0] MODE_INIT   = 2'd0;
  localparam logic [1:0] MODE_CMD    = 2'd1;
  localparam logic [1:0] MODE_DATA   = 2'd2;
  localparam logic [1:0] MODE_CURSOR = 2'd3;

  // Register indexes on the configuration port.
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  localparam logic [1:0] ROWS_RESET = 2'd2;
  localparam logic [5:0] COLS_RESET = 6'd8;
  localparam logic [1:0] MAX_LINES  = 2'd2;
  localparam logic [5:0] MAX_COLS   = 6'd40;

  // Controller command codes.
  localparam logic [7:0] CMD_CLEAR    = 8'h01;
  localparam logic [7:0] CMD_HOME     = 8'h02;
  localparam logic [7:0] SET_ADDR_CMD = 8'h80;
  localparam logic [6:0] LINE1_BASE   = 7'h40;

  localparam logic [7:0] CMD_FUNC_SET  = 8'h28;
  localparam logic [7:0] CMD_DISP_OFF  = 8'h08;
  localparam logic [7:0] CMD_ENTRY     = 8'h06;
  localparam logic [7:0] CMD_DISP_ON   = 8'h0C;

  localparam logic [3:0] WAKE_NIB      = 4'h3;
  localparam logic [3:0] FOUR_BIT_NIB  = 4'h2;

  // Hold times in microseconds.
  localparam logic [15:0] WAIT_POWER_UP = 16'd40000;
  localparam logic [15:0] WAIT_WAKE0    = 16'd5050;
  localparam logic [15:0] WAIT_WAKE     = 16'd200;
  localparam logic [15:0] WAIT_HIGH     = 16'd50;
  localparam logic [15:0] WAIT_LOW      = 16'd100;
  localparam logic [15:0] WAIT_LONG     = 16'd2050;

  // Step numbers of the last result of each kind of request, and of the first init command step.
  localparam logic [3:0] INIT_LAST_STEP  = 4'd14;
  localparam logic [3:0] BYTE_LAST_STEP  = 4'd1;
  localparam logic [3:0] INIT_CMD_START  = 4'd5;

  // Register values as seen by the classifier.
  typedef struct packed {
    logic [1:0] rows;
    logic [5:0] cols;
  } cfg_t;

  // One queued job for the back end.
  typedef struct packed {
    logic       is_init;
    logic       rs;
    logic       long_wait;
    logic [7:0] value;
  } job_t;

  // One bus transfer result, without the end-of-request mark.
  typedef struct packed {
    logic        strobe;
    logic        rs;
    logic [3:0]  nibble;
    logic [15:0] wait_us;
  } xfer_t;

  // Setup command sent in init slot idx.
  function automatic logic [7:0] setup_cmd(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = CMD_FUNC_SET;
      3'd1:    c = CMD_DISP_OFF;
      3'd2:    c = CMD_CLEAR;
      3'd3:    c = CMD_ENTRY;
      3'd4:    c = CMD_DISP_ON;
      default: c = CMD_DISP_ON;
    endcase
    return c;
  endfunction

  // Transfer for one step of the init sequence.
  function automatic xfer_t init_xfer(input logic [3:0] step);
    xfer_t      x;
    logic [3:0] ofs;
    logic [7:0] c;
    ofs = step - INIT_CMD_START;
    c   = setup_cmd(ofs[3:1]);
    x.strobe = 1'b1;
    x.rs     = 1'b0;
    unique case (step)
      4'd0: begin
        x.strobe  = 1'b0;
        x.nibble  = 4'h0;
        x.wait_us = WAIT_POWER_UP;
      end
      4'd1: begin
        x.nibble  = WAKE_NIB;
        x.wait_us = WAIT_WAKE0;
      end
      4'd2, 4'd3: begin
        x.nibble  = WAKE_NIB;
        x.wait_us = WAIT_WAKE;
      end
      4'd4: begin
        x.nibble  = FOUR_BIT_NIB;
        x.wait_us = WAIT_WAKE;
      end
      default: begin
        if (ofs[0] == 1'b0) begin
          x.nibble  = c[7:4];
          x.wait_us = WAIT_HIGH;
        end else begin
          x.nibble  = c[3:0];
          x.wait_us = (c == CMD_CLEAR) ? WAIT_LONG : WAIT_LOW;
        end
      end
    endcase
    return x;
  endfunction

  // Transfer for one step of a job.
  function automatic xfer_t job_xfer(input job_t j, input logic [3:0] step);
    xfer_t x;
    x = init_xfer(step);
    if (!j.is_init) begin
      x.strobe = 1'b1;
      x.rs     = j.rs;
      if (step[0] == 1'b0) begin
        x.nibble  = j.value[7:4];
        x.wait_us = WAIT_HIGH;
      end else begin
        x.nibble  = j.value[3:0];
        x.wait_us = j.long_wait ? WAIT_LONG : WAIT_LOW;
      end
    end
    return x;
  endfunction

endpackage
`default_nettype wire

// ===== src/char_lcd_nibble_sequencer_core.sv =====
// Top level of the character LCD nibble sequencer: register port, front end, queue, back end.
//
// Usage:
//   Requests arrive on the s_ stream (mode, byte, row, col). Each request turns into a
//   run of LCD bus transfer words on the m_ stream; m_tlast marks the last word of a run,
//   m_tuser is set for a nibble strobe and clear for a pure wait.
//   An init request gives 15 words, a command, data or valid cursor request gives 2,
//   and a cursor request outside the configured rows or columns gives none.
//   rows_in_use (address 0) and cols_in_use (address 4) are set on the APB port.
// Timing:
//   When the back end is free, the first word of a request passes through the queue and
//   then the output register. The back end emits one word per cycle while m_tready is
//   high; the output register sets this rate.
//   A queue of QUEUE_DEPTH jobs lets requests be accepted while words wait.
// Reset:
//   rst empties the queue and the output register and sets rows_in_use to 2 and
//   cols_in_use to 8.
// Stalls:
//   When m_tready is low the current word holds; the front keeps taking requests until
//   the queue fills, then s_tready drops.
`default_nettype none
module char_lcd_nibble_sequencer_core
  import lcdseq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,  // mode[1:0], byte_value[9:2], row[11:10], col[17:12]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,  // reg_select[0], nibble[4:1], wait_us[20:5]
  output logic             m_tuser,  // strobe_res
  output logic             m_tlast,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t cfg;
  logic cfg_we;
  logic push;
  logic pop;
  job_t push_job;
  job_t head;
  logic q_empty;
  logic q_full;

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rows <= ROWS_RESET;
      cfg.cols <= COLS_RESET;
    end else if (cfg_we) begin
      unique case (paddr[2])
        REG_ROWS: cfg.rows <= pwdata[1:0];
        REG_COLS: cfg.cols <= pwdata[5:0];
        default:  cfg.rows <= cfg.rows;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_ROWS: prdata = {30'd0, cfg.rows};
      REG_COLS: prdata = {26'd0, cfg.cols};
      default:  prdata = 32'd0;
    endcase
  end

  lcdseq_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .cfg      (cfg),
    .q_full   (q_full),
    .push     (push),
    .job      (push_job)
  );

  lcdseq_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  lcdseq_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_empty  (q_empty),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // A job is never taken from an empty queue.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst) pop |-> !q_empty)
    else $error("job taken from empty queue");

  // A job is never written into a full queue.
  a_push_room: assert property (@(posedge clk) disable iff (rst) push |-> !q_full)
    else $error("job written into full queue");

  // A pure wait is only the power-up hold and never ends a run.
  a_wait_word: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata[20:5] == WAIT_POWER_UP && m_tdata[4:0] == 5'd0
                                && !m_tlast))
    else $error("malformed pure wait word");

  // A word that stalls is followed by another valid word of the same run end.
  a_stall_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tlast)))
    else $error("stalled word changed");

endmodule
`default_nettype wire

// ===== src/lcdseq_front.sv =====
// Front end: decodes requests, checks cursor positions and builds queue jobs.
`default_nettype none
module lcdseq_front
  import lcdseq_pkg::*;
(
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,  // mode[1:0], byte_value[9:2], row[11:10], col[17:12]
  input  wire cfg_t        cfg,
  input  wire logic        q_full,
  output logic             push,
  output job_t             job
);

  logic [1:0] mode;
  logic [7:0] byte_value;
  logic [1:0] row;
  logic [5:0] col;
  logic [1:0] lines_lim;
  logic [5:0] cols_lim;
  logic       reject;
  logic [6:0] addr;

  assign mode       = s_tdata[1:0];
  assign byte_value = s_tdata[9:2];
  assign row        = s_tdata[11:10];
  assign col        = s_tdata[17:12];

  // Limits saturate at the largest display size.
  assign lines_lim = (cfg.rows > MAX_LINES) ? MAX_LINES : cfg.rows;
  assign cols_lim  = (cfg.cols > MAX_COLS) ? MAX_COLS : cfg.cols;

  // Line 1 starts at a fixed DDRAM offset.
  assign addr = (row == 2'd0) ? {1'b0, col} : (LINE1_BASE + {1'b0, col});

  // Build the job; a rejected cursor request is taken and dropped.
  always_comb begin
    job.is_init   = 1'b0;
    job.rs        = 1'b0;
    job.value     = byte_value;
    reject        = 1'b0;
    unique case (mode)
      MODE_INIT: job.is_init = 1'b1;
      MODE_CMD:  job.rs      = 1'b0;
      MODE_DATA: job.rs      = 1'b1;
      MODE_CURSOR: begin
        job.value = SET_ADDR_CMD | {1'b0, addr};
        reject    = (row >= lines_lim) || (col >= cols_lim);
      end
      default: job.is_init = 1'b0;
    endcase
    job.long_wait = !job.rs && ((job.value == CMD_CLEAR) || (job.value == CMD_HOME));
  end

  assign s_tready = !q_full;
  assign push     = s_tvalid && s_tready && !reject;

endmodule
`default_nettype wire

// ===== src/lcdseq_queue.sv =====
// Short job queue between the front end and the back end.
`default_nettype none
module lcdseq_queue
  import lcdseq_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_job,
  input  wire logic pop,
  output job_t      head,
  output logic      empty,
  output logic      full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign empty = (count == '0);
  assign full  = (count == CW'(DEPTH));
  assign head  = slots[rd_ptr];

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/lcdseq_back.sv =====
// Back end: expands jobs into transfer results, one per cycle unless m_tready stalls, into an output register.
`default_nettype none
module lcdseq_back
  import lcdseq_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire job_t        head,
  input  wire logic        q_empty,
  output logic             pop,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,  // reg_select[0], nibble[4:1], wait_us[20:5]
  output logic             m_tuser,  // strobe_res
  output logic             m_tlast
);

  logic       active;
  job_t       cur;
  logic [3:0] step;
  logic       load;
  logic       have;
  job_t       src;
  logic [3:0] src_step;
  logic [3:0] last_step;
  logic       at_end;
  xfer_t      x;
  xfer_t      out_x;

  // Work from the held job, or start the next one at its first step.
  assign load      = !m_tvalid || m_tready;
  assign have      = active || !q_empty;
  assign src       = active ? cur : head;
  assign src_step  = active ? step : 4'd0;
  assign last_step = src.is_init ? INIT_LAST_STEP : BYTE_LAST_STEP;
  assign at_end    = (src_step == last_step);
  assign x         = job_xfer(src, src_step);
  assign pop       = load && !active && !q_empty;

  // Step counter and held job.
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      step   <= 4'd0;
    end else if (load && have) begin
      active <= !at_end;
      step   <= src_step + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= have;
    end
  end

  always_ff @(posedge clk) begin
    if (load && have) begin
      out_x   <= x;
      m_tlast <= at_end;
    end
  end

  assign m_tuser = out_x.strobe;
  assign m_tdata = {3'b000, out_x.wait_us, out_x.nibble, out_x.rs};

endmodule
`default_nettype wire

// ===== tb/lcd_xfer_checker.sv =====
// Checker for the character LCD nibble sequencer: predicts transfer words and compares them.
`default_nettype none
module lcd_xfer_checker
  import lcdseq_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [23:0] s_tdata,   // mode[1:0], byte_value[9:2], row[11:10], col[17:12]
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [23:0] m_tdata,   // reg_select[0], nibble[4:1], wait_us[20:5]
  input  wire logic        m_tuser,   // strobe_res
  input  wire logic        m_tlast,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  input  wire logic        pready,
  output int               fail_count,
  output int               words_pending
);

  // One bus transfer word as the sequencer should emit it.
  typedef struct packed {
    logic        strobe;
    logic        rs;
    logic [3:0]  nibble;
    logic [15:0] wait_us;
    logic        last;
  } lcd_word_t;

  lcd_word_t  xfers_due[$];
  logic [1:0] rows_cfg;
  logic [5:0] cols_cfg;

  initial begin
    fail_count    = 0;
    words_pending = 0;
  end

  // Prints one line per mismatch and counts it.
  task automatic note_mismatch(input string field, input int want, input int got);
    $display("checker: %s: expected %0d, got %0d", field, want, got);
    fail_count++;
  endtask

  task automatic plan_xfer(input logic strobe, input logic rs, input logic [3:0] nib,
                           input logic [15:0] hold);
    lcd_word_t w;
    w.strobe  = strobe;
    w.rs      = rs;
    w.nibble  = nib;
    w.wait_us = hold;
    w.last    = 1'b0;
    xfers_due.push_back(w);
  endtask

  // A byte goes out high nibble first; clear and home need the long hold on commands.
  task automatic plan_byte(input logic [7:0] value, input logic rs);
    logic [15:0] second_hold;
    second_hold = WAIT_LOW;
    if (!rs && (value == CMD_CLEAR || value == CMD_HOME)) begin
      second_hold = WAIT_LONG;
    end
    plan_xfer(1'b1, rs, value[7:4], WAIT_HIGH);
    plan_xfer(1'b1, rs, value[3:0], second_hold);
  endtask

  // Expands one request into the words it should produce.
  task automatic plan_request(input logic [1:0] mode, input logic [7:0] value,
                              input logic [1:0] row, input logic [5:0] col);
    int         prior_count;
    logic [1:0] line_limit;
    logic [5:0] col_limit;
    logic [6:0] addr;
    lcd_word_t  w;
    prior_count = xfers_due.size();
    case (mode)
      MODE_INIT: begin
        plan_xfer(1'b0, 1'b0, 4'h0, WAIT_POWER_UP);
        plan_xfer(1'b1, 1'b0, WAKE_NIB, WAIT_WAKE0);
        plan_xfer(1'b1, 1'b0, WAKE_NIB, WAIT_WAKE);
        plan_xfer(1'b1, 1'b0, WAKE_NIB, WAIT_WAKE);
        plan_xfer(1'b1, 1'b0, FOUR_BIT_NIB, WAIT_WAKE);
        plan_byte(CMD_FUNC_SET, 1'b0);
        plan_byte(CMD_DISP_OFF, 1'b0);
        plan_byte(CMD_CLEAR, 1'b0);
        plan_byte(CMD_ENTRY, 1'b0);
        plan_byte(CMD_DISP_ON, 1'b0);
      end
      MODE_CMD: begin
        plan_byte(value, 1'b0);
      end
      MODE_DATA: begin
        plan_byte(value, 1'b1);
      end
      MODE_CURSOR: begin
        // The register limits saturate at the display's physical size.
        line_limit = (rows_cfg > MAX_LINES) ? MAX_LINES : rows_cfg;
        col_limit  = (cols_cfg > MAX_COLS) ? MAX_COLS : cols_cfg;
        if (row < line_limit && col < col_limit) begin
          addr = (row == 2'd0) ? {1'b0, col} : LINE1_BASE + {1'b0, col};
          plan_byte(SET_ADDR_CMD | {1'b0, addr}, 1'b0);
        end
      end
    endcase
    if (xfers_due.size() > prior_count) begin
      w = xfers_due.pop_back();
      w.last = 1'b1;
      xfers_due.push_back(w);
    end
  endtask

  // Register writes, accepted requests and accepted words, all sampled at the clock edge.
  always @(posedge clk) begin : watch
    lcd_word_t want;
    if (rst) begin
      rows_cfg = ROWS_RESET;
      cols_cfg = COLS_RESET;
      xfers_due.delete();
      words_pending <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_ROWS) begin
          rows_cfg = pwdata[1:0];
        end else if (paddr[2] == REG_COLS) begin
          cols_cfg = pwdata[5:0];
        end
      end
      if (s_tvalid && s_tready) begin
        plan_request(s_tdata[1:0], s_tdata[9:2], s_tdata[11:10], s_tdata[17:12]);
      end
      if (m_tvalid && m_tready) begin
        if (xfers_due.size() == 0) begin
          note_mismatch("words waiting", 1, 0);
        end else begin
          want = xfers_due.pop_front();
          if (m_tuser !== want.strobe) begin
            note_mismatch("strobe_res", int'(want.strobe), int'(m_tuser));
          end
          if (m_tdata[0] !== want.rs) begin
            note_mismatch("reg_select", int'(want.rs), int'(m_tdata[0]));
          end
          if (m_tdata[4:1] !== want.nibble) begin
            note_mismatch("nibble", int'(want.nibble), int'(m_tdata[4:1]));
          end
          if (m_tdata[20:5] !== want.wait_us) begin
            note_mismatch("wait_us", int'(want.wait_us), int'(m_tdata[20:5]));
          end
          if (m_tlast !== want.last) begin
            note_mismatch("last", int'(want.last), int'(m_tlast));
          end
        end
      end
      words_pending <= xfers_due.size();
    end
  end

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Testbench top for the character LCD nibble sequencer: clock, reset, stimulus and verdict.
`default_nettype none
module tb;
  import lcdseq_pkg::*;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic [23:0] s_tdata  = '0;
  logic        m_tready = 1'b0;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;

  logic        s_tready;
  logic        m_tvalid;
  logic [23:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;
  logic [31:0] prdata;
  logic        pready;

  int          fail_count;
  int          words_pending;

  // When set, neither side inserts idle cycles.
  bit          steady = 1'b0;
  logic [1:0]  rows_set = ROWS_RESET;
  logic [5:0]  cols_set = COLS_RESET;

  char_lcd_nibble_sequencer_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  lcd_xfer_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .fail_count(fail_count), .words_pending(words_pending)
  );

  always #10 clk = ~clk;

  // Idle lengths: mostly none or short, now and then long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offers one request word and holds it until it is taken.
  task automatic send_request(input logic [1:0] mode, input logic [7:0] value,
                              input logic [1:0] row, input logic [5:0] col);
    int gap;
    gap = steady ? 0 : gap_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 24'($urandom);
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, col, row, value, mode};
    do @(posedge clk); while (!s_tready);
  endtask

  // Stops sending and waits until every predicted word has come out.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_geometry(input logic [1:0] rows, input logic [5:0] cols);
    drain();
    write_reg(REG_ROWS, {30'd0, rows});
    write_reg(REG_COLS, {26'd0, cols});
    rows_set = rows;
    cols_set = cols;
  endtask

  // Random request, shaped so that most cursor moves land inside the display.
  task automatic send_random();
    int         pick;
    logic [1:0] mode;
    logic [7:0] value;
    logic [1:0] row;
    logic [5:0] col;
    logic [1:0] line_limit;
    logic [5:0] col_limit;
    pick  = $urandom_range(0, 99);
    value = 8'($urandom);
    row   = 2'($urandom);
    col   = 6'($urandom);
    if (pick < 4) mode = MODE_INIT;
    else if (pick < 34) mode = MODE_CMD;
    else if (pick < 64) mode = MODE_DATA;
    else mode = MODE_CURSOR;
    if (mode != MODE_CURSOR && $urandom_range(0, 4) == 0) begin
      value = 8'($urandom_range(0, 3));
    end
    line_limit = (rows_set > MAX_LINES) ? MAX_LINES : rows_set;
    col_limit  = (cols_set > MAX_COLS) ? MAX_COLS : cols_set;
    if (mode == MODE_CURSOR && line_limit != 0 && col_limit != 0
        && $urandom_range(0, 4) != 0) begin
      row = 2'($urandom_range(0, line_limit - 1));
      col = 6'($urandom_range(0, col_limit - 1));
    end
    send_request(mode, value, row, col);
  endtask

  // Ready side: random stalls unless a steady stretch is running.
  initial begin : sink
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (stall > 0 && !steady) begin
        m_tready <= 1'b0;
        stall--;
      end else begin
        m_tready <= 1'b1;
        stall = ($urandom_range(0, 2) == 0) ? gap_len() : 0;
      end
    end
  end

  initial begin : stimulus
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: init, byte extremes, clear and home on both registers.
    send_request(MODE_INIT, 8'($urandom), 2'($urandom), 6'($urandom));
    send_request(MODE_CMD, 8'h00, 2'($urandom), 6'($urandom));
    send_request(MODE_CMD, 8'hFF, 2'($urandom), 6'($urandom));
    send_request(MODE_CMD, CMD_CLEAR, 2'($urandom), 6'($urandom));
    send_request(MODE_CMD, CMD_HOME, 2'($urandom), 6'($urandom));
    send_request(MODE_CMD, 8'h03, 2'($urandom), 6'($urandom));
    send_request(MODE_DATA, CMD_CLEAR, 2'($urandom), 6'($urandom));
    send_request(MODE_DATA, CMD_HOME, 2'($urandom), 6'($urandom));
    send_request(MODE_DATA, 8'hFF, 2'($urandom), 6'($urandom));
    send_request(MODE_DATA, 8'h00, 2'($urandom), 6'($urandom));

    // Cursor moves at the reset geometry, in and out of range.
    send_request(MODE_CURSOR, 8'($urandom), 2'd0, 6'd0);
    send_request(MODE_CURSOR, 8'($urandom), 2'd1, 6'd7);
    send_request(MODE_CURSOR, 8'($urandom), 2'd0, 6'd8);
    send_request(MODE_CURSOR, 8'($urandom), 2'd2, 6'd0);
    send_request(MODE_CURSOR, 8'($urandom), 2'd3, 6'd63);
    send_request(MODE_CURSOR, 8'($urandom), 2'd1, 6'd0);

    // Registers above the display size saturate.
    set_geometry(2'd3, 6'd63);
    send_request(MODE_CURSOR, 8'($urandom), 2'd1, 6'd39);
    send_request(MODE_CURSOR, 8'($urandom), 2'd0, 6'd40);
    send_request(MODE_CURSOR, 8'($urandom), 2'd2, 6'd5);
    send_request(MODE_CURSOR, 8'($urandom), 2'd1, 6'd63);

    // Zero registers reject every cursor move.
    set_geometry(2'd0, 6'd0);
    send_request(MODE_CURSOR, 8'($urandom), 2'd0, 6'd0);

    set_geometry(2'd1, 6'd40);
    send_request(MODE_CURSOR, 8'($urandom), 2'd0, 6'd39);
    send_request(MODE_CURSOR, 8'($urandom), 2'd1, 6'd0);

    set_geometry(2'd2, 6'd1);
    send_request(MODE_CURSOR, 8'($urandom), 2'd1, 6'd0);
    send_request(MODE_CURSOR, 8'($urandom), 2'd0, 6'd1);

    // Random phases, each under its own geometry; the first runs without idling.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: set_geometry(2'd2, 6'd16);
        2: set_geometry($urandom_range(0, 1) ? 2'd3 : 2'd0, 6'd63);
        default: set_geometry(2'($urandom_range(1, 2)), 6'($urandom_range(1, 40)));
      endcase
      steady = (phase == 0);
      for (int n = 0; n < 24; n++) begin
        if (phase == 3 && n == 12) drain();
        send_random();
      end
    end
    steady = 1'b0;

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin : watchdog
    #10_000_000;
    $display("tb: done, errors");
    $finish;
  end

endmodule
`default_nettype wire
